/* src/glob_wildcard_matcher_macros.svh */
// Assertion macros for the glob wildcard matcher checker.
// Each macro expands to one labeled concurrent assertion on a clock edge.
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// a implies b in the same cycle, disabled during reset
`define GWM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("gwm check failed");

// a implies b in the next cycle, disabled during reset
`define GWM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("gwm check failed");

`endif

/* src/gwm_pkg.sv */
// Package for the glob wildcard matcher: pattern characters, request codes,
// default sizes and the result bundle. No dependencies.
`timescale 1ns / 1ps

package gwm_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int TEXT_MAX_DEF    = 256;
    localparam int LEN_W           = 9;

    // request codes
    localparam logic [1:0] REQ_CLR_PAT = 2'd0;
    localparam logic [1:0] REQ_APP_PAT = 2'd1;
    localparam logic [1:0] REQ_APP_TXT = 2'd2;
    localparam logic [1:0] REQ_EVAL    = 2'd3;

    // pattern characters
    localparam logic [7:0] CH_ANY   = 8'h3F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_NOT1  = 8'h21;
    localparam logic [7:0] CH_NOT2  = 8'h5E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ESC   = 8'h5C;

    // result of one evaluation
    typedef struct packed {
        logic hit;
        logic pvalid;
        logic ovf;
    } t_res;

endpackage

/* src/glob_wildcard_matcher.sv */
// Glob wildcard matcher: input handshake, pattern and text stores, search
// sequencer and output register. Uses gwm_pkg, gwm_store and gwm_seq.
//
// Input channel: i_valid/o_ready carry i_req_type and i_char_byte.
//   Clear pattern and append items give no result.
//   An evaluate item gives one result on o_valid/i_ready and clears the text.
// Evaluate sequence: a start step, then the backslash scan over the pattern
//   bytes (an escape pair taken in one step), then the search at one byte
//   compare per cycle, with extra steps for set parsing and each star retry;
//   the result then waits in S_DONE for a free output register and is then
//   registered. The search is bounded by the single-port reads of the pattern
//   and text stores and revisits text positions after each star.
// o_ready is low while an evaluate runs and while a finished result cannot
//   move into a full output register stalled by i_ready.
// Reset (synchronous, active low) empties both stores and clears overflow
//   flags; store contents stay undefined and are never read unwritten.
`timescale 1ns / 1ps

module glob_wildcard_matcher #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = gwm_pkg::TEXT_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [7:0]                 i_char_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_matched,
    output logic [gwm_pkg::LEN_W-1:0]  o_match_length,
    output logic                       o_pattern_valid,
    output logic                       o_overflow
);
    localparam int PW  = $clog2(PATTERN_MAX + 1) + 1;
    localparam int TW  = $clog2(TEXT_MAX + 1) + 1;
    localparam int PCW = $clog2(PATTERN_MAX + 1);
    localparam int TCW = $clog2(TEXT_MAX + 1);

    logic             acc, busy, done, out_free;
    logic [PW-1:0]    paddr;
    logic [TW-1:0]    taddr;
    logic [7:0]       pdat, tdat;
    logic [PCW-1:0]   pcount;
    logic [TCW-1:0]   tcount;
    logic             povf, tovf;
    gwm_pkg::t_res    res;

    logic                      r_valid;
    logic                      r_matched, r_pvalid, r_ovf;
    logic [gwm_pkg::LEN_W-1:0] r_len;

    assign o_ready  = !busy;
    assign acc      = i_valid && o_ready;
    assign out_free = !r_valid || i_ready;

    gwm_store #(.DEPTH(PATTERN_MAX), .AW(PW)) u_pat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (acc && i_req_type == gwm_pkg::REQ_CLR_PAT),
        .i_append   (acc && i_req_type == gwm_pkg::REQ_APP_PAT),
        .i_byte     (i_char_byte),
        .i_raddr    (paddr),
        .o_rdata    (pdat),
        .o_count    (pcount),
        .o_overflow (povf)
    );

    gwm_store #(.DEPTH(TEXT_MAX), .AW(TW)) u_txt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (done),
        .i_append   (acc && i_req_type == gwm_pkg::REQ_APP_TXT),
        .i_byte     (i_char_byte),
        .i_raddr    (taddr),
        .o_rdata    (tdat),
        .o_count    (tcount),
        .o_overflow (tovf)
    );

    gwm_seq #(.PATTERN_MAX(PATTERN_MAX), .TEXT_MAX(TEXT_MAX), .PW(PW), .TW(TW)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (acc && i_req_type == gwm_pkg::REQ_EVAL),
        .i_ovf      (povf || tovf),
        .i_out_free (out_free),
        .i_pdat     (pdat),
        .i_tdat     (tdat),
        .i_pcount   (pcount),
        .o_paddr    (paddr),
        .o_taddr    (taddr),
        .o_busy     (busy),
        .o_done     (done),
        .o_res      (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_matched <= res.hit;
            r_len     <= res.hit ? gwm_pkg::LEN_W'(tcount) : '0;
            r_pvalid  <= res.pvalid;
            r_ovf     <= res.ovf;
        end
    end

    assign o_valid         = r_valid;
    assign o_matched       = r_matched;
    assign o_match_length  = r_len;
    assign o_pattern_valid = r_pvalid;
    assign o_overflow      = r_ovf;

endmodule

/* src/gwm_store.sv */
// Byte store with append, clear, fill count, overflow flag and a registered
// read port that returns zero past the fill count. Uses gwm_pkg.
`timescale 1ns / 1ps

module gwm_store #(
    parameter int DEPTH = gwm_pkg::PATTERN_MAX_DEF,
    parameter int AW    = $clog2(DEPTH + 1) + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_append,
    input  logic [7:0]                   i_byte,
    input  logic [AW-1:0]                i_raddr,
    output logic [7:0]                   o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic                         o_overflow
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_raddr;

    // fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_append && i_byte != 8'd0) begin
            if (r_count < CW'(DEPTH)) r_count <= r_count + 1'b1;
            else r_ovf <= 1'b1;
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_append && i_byte != 8'd0 && r_count < CW'(DEPTH)) begin
            r_mem[r_count[IW-1:0]] <= i_byte;
        end
        r_rdata <= r_mem[i_raddr[IW-1:0]];
        r_raddr <= i_raddr;
    end

    assign o_rdata    = (r_raddr < AW'(r_count)) ? r_rdata : 8'd0;
    assign o_count    = r_count;
    assign o_overflow = r_ovf;

endmodule

/* src/gwm_seq.sv */
// Sequencer for the backtracking glob search: one byte compare per cycle
// over the pattern and text stores. Uses gwm_pkg.
`timescale 1ns / 1ps

module gwm_seq #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = gwm_pkg::TEXT_MAX_DEF,
    parameter int PW          = $clog2(PATTERN_MAX + 1) + 1,
    parameter int TW          = $clog2(TEXT_MAX + 1) + 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_ovf,
    input  logic                               i_out_free,
    input  logic [7:0]                         i_pdat,
    input  logic [7:0]                         i_tdat,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]   i_pcount,
    output logic [PW-1:0]                      o_paddr,
    output logic [TW-1:0]                      o_taddr,
    output logic                               o_busy,
    output logic                               o_done,
    output gwm_pkg::t_res                      o_res
);
    localparam logic [1:0] R_FALSE = 2'd0;
    localparam logic [1:0] R_TRUE  = 2'd1;
    localparam logic [1:0] R_ABORT = 2'd2;
    localparam logic [1:0] R_STAR  = 2'd3;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_VCHK   = 5'd1;
    localparam logic [4:0] S_MLOOP  = 5'd2;
    localparam logic [4:0] S_MSTAR  = 5'd3;
    localparam logic [4:0] S_MLIT   = 5'd4;
    localparam logic [4:0] S_SNEG   = 5'd5;
    localparam logic [4:0] S_SFIRST = 5'd6;
    localparam logic [4:0] S_SITEM  = 5'd7;
    localparam logic [4:0] S_SLO    = 5'd8;
    localparam logic [4:0] S_SDASH  = 5'd9;
    localparam logic [4:0] S_SHI    = 5'd10;
    localparam logic [4:0] S_SHI2   = 5'd11;
    localparam logic [4:0] S_SCMP   = 5'd12;
    localparam logic [4:0] S_SAFTER = 5'd13;
    localparam logic [4:0] S_SSKIP  = 5'd14;
    localparam logic [4:0] S_ESCAN  = 5'd15;
    localparam logic [4:0] S_ENEXT  = 5'd16;
    localparam logic [4:0] S_LTRY   = 5'd17;
    localparam logic [4:0] S_LPOST  = 5'd18;
    localparam logic [4:0] S_DONE   = 5'd19;

    logic [4:0]    r_state, n_state;
    logic [PW-1:0] r_p, n_p, r_sp, n_sp, r_lp, n_lp;
    logic [TW-1:0] r_t, n_t, r_st, n_st, r_lt, n_lt;
    logic          r_ctx, n_ctx;       // 1: call from the star retry loop
    logic          r_inv, n_inv, r_mem, n_mem;
    logic [7:0]    r_lo, n_lo, r_hi, n_hi, r_nextp, n_nextp;
    logic [1:0]    r_r, n_r;
    logic          r_pvalid, n_pvalid, r_ovf, n_ovf, r_hit, n_hit;

    logic          do_ret, do_fin;
    logic [1:0]    ret_code, fin_code;
    logic [7:0]    pc, tc, mn, mx;
    logic [PW-1:0] pcnt;

    assign pc   = i_pdat;
    assign tc   = i_tdat;
    assign pcnt = PW'(i_pcount);
    assign mn   = (r_lo < r_hi) ? r_lo : r_hi;
    assign mx   = (r_lo < r_hi) ? r_hi : r_lo;

    always_comb begin
        n_state = r_state;  n_p = r_p;  n_t = r_t;
        n_sp = r_sp;  n_st = r_st;  n_lp = r_lp;  n_lt = r_lt;
        n_ctx = r_ctx;  n_inv = r_inv;  n_mem = r_mem;
        n_lo = r_lo;  n_hi = r_hi;  n_nextp = r_nextp;  n_r = r_r;
        n_pvalid = r_pvalid;  n_ovf = r_ovf;  n_hit = r_hit;
        do_ret = 1'b0;  ret_code = R_FALSE;
        do_fin = 1'b0;  fin_code = R_FALSE;
        o_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ovf   = i_ovf;
                    n_p     = '0;
                    n_state = S_VCHK;
                end
            end
            // trailing unescaped backslash check
            S_VCHK: begin
                if (r_p >= pcnt) begin
                    n_pvalid = 1'b1;
                    if (!r_ovf) begin
                        n_p = '0;  n_t = '0;  n_ctx = 1'b0;
                        n_state = S_MLOOP;
                    end else begin
                        do_fin = 1'b1;  fin_code = R_FALSE;
                    end
                end else if (pc == gwm_pkg::CH_ESC) begin
                    if (r_p + 1'b1 >= pcnt) begin
                        n_pvalid = 1'b0;
                        do_fin = 1'b1;  fin_code = R_FALSE;
                    end else begin
                        n_p = r_p + PW'(2);
                    end
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            // straight match loop
            S_MLOOP: begin
                if (pc == 8'd0) begin
                    do_ret = 1'b1;  ret_code = (tc == 8'd0) ? R_TRUE : R_FALSE;
                end else if (tc == 8'd0) begin
                    if (pc == gwm_pkg::CH_STAR) begin
                        n_p = r_p + 1'b1;  n_state = S_MSTAR;
                    end else begin
                        do_ret = 1'b1;  ret_code = R_ABORT;
                    end
                end else if (pc == gwm_pkg::CH_ANY) begin
                    n_p = r_p + 1'b1;  n_t = r_t + 1'b1;
                end else if (pc == gwm_pkg::CH_STAR) begin
                    n_sp = r_p;  n_st = r_t;
                    do_ret = 1'b1;  ret_code = R_STAR;
                end else if (pc == gwm_pkg::CH_OPEN) begin
                    n_p = r_p + 1'b1;  n_inv = 1'b0;  n_mem = 1'b0;
                    n_state = S_SNEG;
                end else if (pc == gwm_pkg::CH_ESC) begin
                    n_p = r_p + 1'b1;  n_state = S_MLIT;
                end else if (pc != tc) begin
                    do_ret = 1'b1;  ret_code = R_FALSE;
                end else begin
                    n_p = r_p + 1'b1;  n_t = r_t + 1'b1;
                end
            end
            S_MSTAR: begin
                do_ret = 1'b1;  ret_code = (pc == 8'd0) ? R_TRUE : R_ABORT;
            end
            S_MLIT: begin
                if (pc != tc) begin
                    do_ret = 1'b1;  ret_code = R_FALSE;
                end else begin
                    n_p = r_p + 1'b1;  n_t = r_t + 1'b1;  n_state = S_MLOOP;
                end
            end
            // bracket set
            S_SNEG: begin
                if (pc == gwm_pkg::CH_NOT1 || pc == gwm_pkg::CH_NOT2) begin
                    n_inv = 1'b1;  n_p = r_p + 1'b1;
                end
                n_state = S_SFIRST;
            end
            S_SFIRST: begin
                if (pc == gwm_pkg::CH_CLOSE) begin
                    do_ret = 1'b1;  ret_code = R_ABORT;
                end else begin
                    n_state = S_SITEM;
                end
            end
            S_SITEM: begin
                if (pc == gwm_pkg::CH_CLOSE) begin
                    n_state = S_SAFTER;
                end else begin
                    if (pc == gwm_pkg::CH_ESC) n_p = r_p + 1'b1;
                    n_state = S_SLO;
                end
            end
            S_SLO: begin
                n_lo = pc;  n_hi = pc;
                if (pc == 8'd0) begin
                    do_ret = 1'b1;  ret_code = R_ABORT;
                end else begin
                    n_p = r_p + 1'b1;  n_state = S_SDASH;
                end
            end
            S_SDASH: begin
                if (pc == gwm_pkg::CH_DASH) begin
                    n_p = r_p + 1'b1;  n_state = S_SHI;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SHI: begin
                n_hi = pc;
                if (pc == 8'd0 || pc == gwm_pkg::CH_CLOSE) begin
                    do_ret = 1'b1;  ret_code = R_ABORT;
                end else begin
                    n_p = r_p + 1'b1;
                    n_state = (pc == gwm_pkg::CH_ESC) ? S_SHI2 : S_SCMP;
                end
            end
            S_SHI2: begin
                n_hi = pc;  n_p = r_p + 1'b1;  n_state = S_SCMP;
            end
            S_SCMP: begin
                if (tc >= mn && tc <= mx) begin
                    n_mem = 1'b1;  n_state = S_SAFTER;
                end else begin
                    n_state = S_SITEM;
                end
            end
            S_SAFTER: begin
                if (r_inv == r_mem) begin
                    do_ret = 1'b1;  ret_code = R_FALSE;
                end else if (r_mem) begin
                    n_state = S_SSKIP;
                end else begin
                    n_p = r_p + 1'b1;  n_t = r_t + 1'b1;  n_state = S_MLOOP;
                end
            end
            // skip the rest of a matched set
            S_SSKIP: begin
                if (pc == gwm_pkg::CH_CLOSE) begin
                    n_p = r_p + 1'b1;  n_t = r_t + 1'b1;  n_state = S_MLOOP;
                end else if (pc == 8'd0) begin
                    do_ret = 1'b1;  ret_code = R_ABORT;
                end else if (pc == gwm_pkg::CH_ESC) begin
                    n_p = r_p + PW'(2);
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            // run of ? and * after a star
            S_ESCAN: begin
                if (pc == gwm_pkg::CH_ANY) begin
                    if (tc == 8'd0) begin
                        do_fin = 1'b1;  fin_code = R_ABORT;
                    end else begin
                        n_t = r_t + 1'b1;  n_p = r_p + 1'b1;
                    end
                end else if (pc == gwm_pkg::CH_STAR) begin
                    n_p = r_p + 1'b1;
                end else if (pc == 8'd0) begin
                    do_fin = 1'b1;  fin_code = R_TRUE;
                end else begin
                    n_lp = r_p;
                    if (pc == gwm_pkg::CH_ESC) begin
                        n_p = r_p + 1'b1;  n_state = S_ENEXT;
                    end else begin
                        n_nextp = pc;  n_state = S_LTRY;
                    end
                end
            end
            S_ENEXT: begin
                n_nextp = pc;  n_p = r_lp;  n_state = S_LTRY;
            end
            // star retry loop over text positions
            S_LTRY: begin
                if (r_nextp == tc || r_nextp == gwm_pkg::CH_OPEN) begin
                    n_lt = r_t;  n_ctx = 1'b1;  n_state = S_MLOOP;
                end else if (tc == 8'd0) begin
                    do_fin = 1'b1;  fin_code = R_ABORT;
                end else begin
                    n_t = r_t + 1'b1;
                end
            end
            S_LPOST: begin
                if (tc == 8'd0) begin
                    do_fin = 1'b1;  fin_code = R_ABORT;
                end else if (r_r != R_FALSE) begin
                    do_fin = 1'b1;  fin_code = r_r;
                end else begin
                    n_t = r_t + 1'b1;  n_state = S_LTRY;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // return from a straight match
        if (do_ret) begin
            if (ret_code == R_STAR) begin
                n_p = n_sp;  n_t = n_st;  n_state = S_ESCAN;
            end else if (!r_ctx) begin
                do_fin = 1'b1;  fin_code = ret_code;
            end else begin
                n_r = ret_code;  n_p = r_lp;  n_t = r_lt;  n_state = S_LPOST;
            end
        end

        if (do_fin) begin
            n_hit   = (fin_code == R_TRUE);
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= '0;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_t     <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp <= n_sp;  r_st <= n_st;  r_lp <= n_lp;  r_lt <= n_lt;
        r_ctx <= n_ctx;  r_inv <= n_inv;  r_mem <= n_mem;
        r_lo <= n_lo;  r_hi <= n_hi;  r_nextp <= n_nextp;  r_r <= n_r;
        r_pvalid <= n_pvalid;  r_ovf <= n_ovf;  r_hit <= n_hit;
    end

    // stores read at the next address, so their data tracks r_p and r_t
    assign o_paddr    = n_p;
    assign o_taddr    = n_t;
    assign o_busy     = (r_state != S_IDLE);
    assign o_res.hit    = r_hit && r_pvalid && !r_ovf;
    assign o_res.pvalid = r_pvalid;
    assign o_res.ovf    = r_ovf;

endmodule

/* src/gwm_checker.sv */
// Port-level checker for glob_wildcard_matcher, bound to the top level.
// Uses gwm_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "glob_wildcard_matcher_macros.svh"

module gwm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_matched,
    input logic [gwm_pkg::LEN_W-1:0]  o_match_length,
    input logic                       o_pattern_valid,
    input logic                       o_overflow
);
    // a match needs a valid pattern and no overflow
    `GWM_ASSERT_IMP(a_hit_clean, i_clk, i_rst_n, o_valid && o_matched, o_pattern_valid && !o_overflow)
    // a miss reports zero length
    `GWM_ASSERT_IMP(a_miss_len, i_clk, i_rst_n, o_valid && !o_matched, o_match_length == '0)
    // a stalled result holds
    `GWM_ASSERT_NEXT(a_hold_m, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_matched))
    `GWM_ASSERT_NEXT(a_hold_len, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_match_length))
    // a stalled full output during an evaluation stays valid
    `GWM_ASSERT_NEXT(a_busy, i_clk, i_rst_n, !o_ready && o_valid && !i_ready, o_valid)

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the glob wildcard matcher: directed table then
// random pattern/text/evaluate sequences, checked against an in-bench matcher.
// Depends on gwm_pkg and glob_wildcard_matcher.
`timescale 1ns / 1ps

module tb_top;

    localparam int PMAX = gwm_pkg::PATTERN_MAX_DEF;
    localparam int TMAX = gwm_pkg::TEXT_MAX_DEF;
    localparam int LW   = gwm_pkg::LEN_W;
    localparam int M_FALSE = 0;
    localparam int M_TRUE  = 1;
    localparam int M_ABORT = 2;
    localparam int M_STAR  = 3;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [1:0]    i_req_type;
    logic [7:0]    i_char_byte;
    logic          o_valid;
    logic          i_ready;
    logic          o_matched;
    logic [LW-1:0] o_match_length;
    logic          o_pattern_valid;
    logic          o_overflow;

    typedef struct {
        logic          matched;
        logic [LW-1:0] len;
        logic          pvalid;
        logic          ovf;
    } t_verdict;

    // directed row: request, byte, whether the result is typed in, and the result
    typedef struct {
        logic [1:0] req;
        logic [7:0] chr;
        bit         fixed;
        t_verdict   want;
    } t_row;

    t_verdict   verdict_q[$];
    int         err_cnt;
    bit         done;

    // in-bench matcher state
    logic [7:0] glob_mem[PMAX];
    int         glob_len;
    bit         glob_ovf;
    logic [7:0] text_mem[TMAX];
    int         text_len;
    bit         text_ovf;
    int         star_p, star_t;

    glob_wildcard_matcher u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int gb(int i);
        return (i < glob_len) ? int'(glob_mem[i]) : 0;
    endfunction

    function automatic int tb(int i);
        return (i < text_len) ? int'(text_mem[i]) : 0;
    endfunction

    function automatic bit glob_well_formed();
        int i;
        i = 0;
        while (i < glob_len) begin
            i++;
            if (glob_mem[i-1] == gwm_pkg::CH_ESC) begin
                if (i >= glob_len) return 1'b0;
                i++;
            end
        end
        return 1'b1;
    endfunction

    // straight match from (p,t); M_STAR records the star position
    function automatic int walk_from(int p0, int t0);
        int p, t, c, pc, lo, hi;
        bit inv, member;
        p = p0;
        t = t0;
        while (gb(p) != 0) begin
            c = tb(t);
            pc = gb(p);
            if (c == 0)
                return (pc == gwm_pkg::CH_STAR && gb(p + 1) == 0) ? M_TRUE : M_ABORT;
            if (pc == gwm_pkg::CH_STAR) begin
                star_p = p;
                star_t = t;
                return M_STAR;
            end
            if (pc == gwm_pkg::CH_OPEN) begin
                inv = 1'b0;
                member = 1'b0;
                p++;
                if (gb(p) == gwm_pkg::CH_NOT1 || gb(p) == gwm_pkg::CH_NOT2) begin
                    inv = 1'b1;
                    p++;
                end
                if (gb(p) == gwm_pkg::CH_CLOSE) return M_ABORT;
                while (gb(p) != gwm_pkg::CH_CLOSE) begin
                    if (gb(p) == gwm_pkg::CH_ESC) p++;
                    lo = gb(p);
                    hi = lo;
                    if (lo == 0) return M_ABORT;
                    p++;
                    if (gb(p) == gwm_pkg::CH_DASH) begin
                        p++;
                        hi = gb(p);
                        if (hi == 0 || hi == gwm_pkg::CH_CLOSE) return M_ABORT;
                        if (hi == gwm_pkg::CH_ESC) begin
                            p++;
                            hi = gb(p);
                        end
                        p++;
                    end
                    if (lo < hi ? (c >= lo && c <= hi) : (c >= hi && c <= lo)) begin
                        member = 1'b1;
                        break;
                    end
                end
                if (inv == member) return M_FALSE;
                if (member) begin
                    while (gb(p) != gwm_pkg::CH_CLOSE) begin
                        if (gb(p) == 0) return M_ABORT;
                        if (gb(p) == gwm_pkg::CH_ESC) p++;
                        p++;
                    end
                end
            end else if (pc != gwm_pkg::CH_ANY) begin
                if (pc == gwm_pkg::CH_ESC) p++;
                if (gb(p) != c) return M_FALSE;
            end
            p++;
            t++;
        end
        return (tb(t) == 0) ? M_TRUE : M_FALSE;
    endfunction

    function automatic int search_text();
        int r, p, t, nx;
        r = walk_from(0, 0);
        while (r == M_STAR) begin
            p = star_p;
            t = star_t;
            while (gb(p) == gwm_pkg::CH_ANY || gb(p) == gwm_pkg::CH_STAR) begin
                if (gb(p) == gwm_pkg::CH_ANY) begin
                    if (tb(t) == 0) return M_ABORT;
                    t++;
                end
                p++;
            end
            if (gb(p) == 0) return M_TRUE;
            nx = gb(p);
            if (nx == gwm_pkg::CH_ESC) nx = gb(p + 1);
            r = M_FALSE;
            forever begin
                if (nx == tb(t) || nx == gwm_pkg::CH_OPEN) begin
                    r = walk_from(p, t);
                    if (r == M_STAR) break;
                end
                if (tb(t) == 0) r = M_ABORT;
                if (r != M_FALSE) return r;
                t++;
            end
        end
        return r;
    endfunction

    // apply one accepted item to the matcher state; queue a verdict on evaluate
    task automatic predict_item(logic [1:0] req, logic [7:0] chr);
        t_verdict v;
        bit hit;
        case (req)
            gwm_pkg::REQ_CLR_PAT: begin
                glob_len = 0;
                glob_ovf = 1'b0;
            end
            gwm_pkg::REQ_APP_PAT: if (chr != 8'd0) begin
                if (glob_len < PMAX) glob_mem[glob_len++] = chr;
                else glob_ovf = 1'b1;
            end
            gwm_pkg::REQ_APP_TXT: if (chr != 8'd0) begin
                if (text_len < TMAX) text_mem[text_len++] = chr;
                else text_ovf = 1'b1;
            end
            default: begin
                v.pvalid = glob_well_formed();
                v.ovf = glob_ovf || text_ovf;
                hit = v.pvalid && !v.ovf && search_text() == M_TRUE;
                v.matched = hit;
                v.len = hit ? LW'(text_len) : '0;
                verdict_q.push_back(v);
                text_len = 0;
                text_ovf = 1'b0;
            end
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    // check results against the oldest pending verdict
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with no pending evaluate");
            end else begin
                v = verdict_q.pop_front();
                if (o_matched !== v.matched)
                    report_mismatch($sformatf("matched %b exp %b", o_matched, v.matched));
                if (o_match_length !== v.len)
                    report_mismatch($sformatf("length %0d exp %0d", o_match_length, v.len));
                if (o_pattern_valid !== v.pvalid)
                    report_mismatch($sformatf("pattern_valid %b exp %b",
                        o_pattern_valid, v.pvalid));
                if (o_overflow !== v.ovf)
                    report_mismatch($sformatf("overflow %b exp %b", o_overflow, v.ovf));
            end
        end
    end

    // receiver stall pattern: random stalls, always ready once the sequences are done
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (($urandom % 256) < 2) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom % 4) != 0 || done;
        end
    end

    int gap_left;

    // one transfer; a random gap may precede it (bursts of random length)
    task automatic send_item(logic [1:0] req, logic [7:0] chr);
        if (gap_left > 0) begin
            i_valid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end else if (($urandom % 12) == 0) begin
            gap_left = $urandom_range(1, 6);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_char_byte <= chr;
        do @(posedge i_clk); while (!o_ready);
        predict_item(req, chr);
    endtask

    task automatic idle_until_drained();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] glob_char();
        case ($urandom % 14)
            0: return gwm_pkg::CH_ANY;
            1, 2: return gwm_pkg::CH_STAR;
            3: return gwm_pkg::CH_OPEN;
            4: return gwm_pkg::CH_CLOSE;
            5: return gwm_pkg::CH_NOT1;
            6: return gwm_pkg::CH_NOT2;
            7: return gwm_pkg::CH_DASH;
            8: return gwm_pkg::CH_ESC;
            9: return 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(8'h61, 8'h64));
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        if (($urandom % 8) == 0) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h61, 8'h64));
    endfunction

    function automatic t_verdict vd(bit m, int l, bit pv, bit ov);
        t_verdict v;
        v.matched = m;
        v.len = LW'(l);
        v.pvalid = pv;
        v.ovf = ov;
        return v;
    endfunction

    t_row rows[$];

    function automatic t_row rw(logic [1:0] r, logic [7:0] c);
        t_row x;
        x.req = r;
        x.chr = c;
        x.fixed = 1'b0;
        return x;
    endfunction

    function automatic t_row rx(t_verdict v);
        t_row x;
        x.req = gwm_pkg::REQ_EVAL;
        x.chr = 8'hFF;
        x.fixed = 1'b1;
        x.want = v;
        return x;
    endfunction

    initial begin
        t_verdict v, w;
        int n, k, plen;
        err_cnt = 0;
        done = 1'b0;
        gap_left = 0;
        glob_len = 0;
        glob_ovf = 1'b0;
        text_len = 0;
        text_ovf = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = gwm_pkg::REQ_CLR_PAT;
        i_char_byte = 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        rows.push_back(rx(vd(1, 0, 1, 0)));                  // empty pattern, empty text
        rows.push_back(rw(gwm_pkg::REQ_APP_TXT, 8'h00));     // zero byte ignored
        rows.push_back(rw(gwm_pkg::REQ_APP_TXT, 8'hFF));
        rows.push_back(rx(vd(0, 0, 1, 0)));                  // empty pattern, text
        rows.push_back(rw(gwm_pkg::REQ_APP_PAT, gwm_pkg::CH_STAR));
        rows.push_back(rw(gwm_pkg::REQ_APP_TXT, 8'h01));
        rows.push_back(rx(vd(1, 1, 1, 0)));
        rows.push_back(rx(vd(1, 0, 1, 0)));                  // single star, empty text
        rows.push_back(rw(gwm_pkg::REQ_APP_PAT, gwm_pkg::CH_STAR));
        rows.push_back(rx(vd(0, 0, 1, 0)));                  // double star at text end
        rows.push_back(rw(gwm_pkg::REQ_CLR_PAT, 8'h00));
        rows.push_back(rw(gwm_pkg::REQ_APP_PAT, gwm_pkg::CH_ESC));
        rows.push_back(rw(gwm_pkg::REQ_APP_TXT, gwm_pkg::CH_ESC));
        rows.push_back(rx(vd(0, 0, 0, 0)));                  // trailing backslash
        rows.push_back(rw(gwm_pkg::REQ_CLR_PAT, 8'h00));
        rows.push_back(rw(gwm_pkg::REQ_APP_PAT, gwm_pkg::CH_OPEN));
        rows.push_back(rw(gwm_pkg::REQ_APP_PAT, gwm_pkg::CH_CLOSE));
        rows.push_back(rw(gwm_pkg::REQ_APP_TXT, 8'h61));
        rows.push_back(rx(vd(0, 0, 1, 0)));                  // empty set
        rows.push_back(rw(gwm_pkg::REQ_CLR_PAT, 8'h00));
        foreach (rows[i]) begin
            if (rows[i].fixed) idle_until_drained();
            send_item(rows[i].req, rows[i].chr);
            if (rows[i].fixed) begin
                v = verdict_q[$];
                w = rows[i].want;
                if (v.matched !== w.matched || v.len !== w.len ||
                    v.pvalid !== w.pvalid || v.ovf !== w.ovf)
                    report_mismatch($sformatf("row %0d predictor", i));
            end
        end

        // store overflow: pattern past its store, then text past its store
        for (k = 0; k <= PMAX; k++) send_item(gwm_pkg::REQ_APP_PAT, gwm_pkg::CH_ANY);
        send_item(gwm_pkg::REQ_APP_TXT, 8'h61);
        send_item(gwm_pkg::REQ_EVAL, 8'h00);
        send_item(gwm_pkg::REQ_CLR_PAT, 8'h00);
        send_item(gwm_pkg::REQ_APP_PAT, gwm_pkg::CH_STAR);
        for (k = 0; k < TMAX; k++)
            send_item(gwm_pkg::REQ_APP_TXT, 8'($urandom_range(1, 255)));
        send_item(gwm_pkg::REQ_EVAL, 8'h00);                 // full text, length 256
        for (k = 0; k <= TMAX; k++) send_item(gwm_pkg::REQ_APP_TXT, 8'h62);
        send_item(gwm_pkg::REQ_EVAL, 8'h00);
        idle_until_drained();

        // random sequences: new pattern now and then, texts and evaluates
        n = 0;
        while (n < 1050) begin
            if (($urandom % 4) == 0) begin
                send_item(gwm_pkg::REQ_CLR_PAT, 8'($urandom));
                plen = $urandom_range(0, 10);
                for (k = 0; k < plen; k++) send_item(gwm_pkg::REQ_APP_PAT, glob_char());
                n += plen + 1;
            end
            plen = $urandom_range(0, 12);
            for (k = 0; k < plen; k++)
                send_item(gwm_pkg::REQ_APP_TXT, ($urandom % 20) == 0 ? 8'h00 : text_char());
            if (($urandom % 10) == 0)
                send_item(2'($urandom), 8'($urandom));     // stray noise item
            send_item(gwm_pkg::REQ_EVAL, 8'($urandom));
            n += plen + 1;
            if (($urandom % 40) == 0) idle_until_drained();
        end

        i_valid <= 1'b0;
        done = 1'b1;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/gwm_pkg.sv
src/gwm_store.sv
src/gwm_seq.sv
src/glob_wildcard_matcher.sv
src/gwm_checker.sv
dv/tb_top.sv
